// ===== hdl/pvmt_pkg.sv =====
// Shared types and codes for the port VLAN membership table.
package pvmt_pkg;

    localparam int VID_W  = 12;
    localparam int REQ_W  = 2;
    localparam int MODE_W = 2;
    localparam int ST_W   = 3;

    // Request types
    localparam logic [REQ_W-1:0] REQ_SET_MODE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_VLAN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MARK_IP  = 2'd2;

    // L2 modes
    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACCESS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRUNK   = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_APPLIED  = 3'd0;
    localparam logic [ST_W-1:0] ST_NOCHANGE = 3'd1;
    localparam logic [ST_W-1:0] ST_CLEARED  = 3'd2;
    localparam logic [ST_W-1:0] ST_L3       = 3'd3;
    localparam logic [ST_W-1:0] ST_NOL2     = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd5;

    // Outcome of comparing one slot against the requested VLAN
    typedef struct packed {
        logic hit;
        logic empty;
    } cmp_res_t;

endpackage

// ===== hdl/pvmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pvmt_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/pvmt_slot_cmp.sv =====
// Shared slot comparator: checks one slot for a match or for being empty.
module pvmt_slot_cmp (
    input  logic [pvmt_pkg::VID_W-1:0] slot_data,
    input  logic                       slot_valid,
    input  logic [pvmt_pkg::VID_W-1:0] vid,
    output pvmt_pkg::cmp_res_t         res
);

    logic [pvmt_pkg::VID_W-1:0] entry;

    // A slot that has not been written since it was cleared reads as empty.
    assign entry     = slot_valid ? slot_data : '0;
    assign res.hit   = (entry == vid);
    assign res.empty = (entry == '0);

endmodule

// ===== hdl/port_vlan_membership_table_top.sv =====
// Top level of the port VLAN membership table: sequencer, mode state and slot store.
//
// Usage: a request word (req_type, mode_req, vlan_number) is taken on a rising
// edge where start is high and busy is low. Exactly one result word (status,
// mode_now) follows, shown for one cycle with done high; the receiver cannot
// stall, so it must capture the word in that cycle.
// Set-mode, mark-IP, refused requests and access-mode add-VLAN need no walk:
// done rises in the cycle after acceptance. A trunk-mode add-VLAN walks the
// slot RAM one slot per cycle through the shared comparator, reading the next
// slot while checking the current one, and stops at the first matching or
// empty slot or at the last slot; the single RAM read port sets this pace.
// busy is high while the walk runs and a new request may be accepted in the
// cycle in which done is high.
// Reset clears the mode to unknown, the IP flag and the per-slot valid bits,
// so every slot reads as empty at once; no clearing pass is needed.
module port_vlan_membership_table_top #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [pvmt_pkg::REQ_W-1:0]  req_type,
    input  logic                        mode_req,
    input  logic [pvmt_pkg::VID_W-1:0]  vlan_number,
    output logic                        done,
    output logic [pvmt_pkg::ST_W-1:0]   status,
    output logic [pvmt_pkg::MODE_W-1:0] mode_now
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_SCAN = 1'b1;

    logic [0:0]                  state_reg, state_next;
    logic [pvmt_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic                        ip_reg, ip_next;
    logic [SLOT_COUNT-1:0]       valid_reg, valid_next;
    logic [IDX_W-1:0]            chk_idx_reg, chk_idx_next;
    logic [pvmt_pkg::VID_W-1:0]  vid_reg, vid_next;
    logic                        done_reg, done_next;
    logic [pvmt_pkg::ST_W-1:0]   status_reg, status_next;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [pvmt_pkg::VID_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]            ram_raddr;
    logic [pvmt_pkg::VID_W-1:0]  ram_rdata;
    logic [pvmt_pkg::MODE_W-1:0] want_mode;
    pvmt_pkg::cmp_res_t          cmp_res;

    pvmt_ram #(
        .WIDTH(pvmt_pkg::VID_W),
        .DEPTH(SLOT_COUNT)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    pvmt_slot_cmp u_slot_cmp (
        .slot_data (ram_rdata),
        .slot_valid(valid_reg[chk_idx_reg]),
        .vid       (vid_reg),
        .res       (cmp_res)
    );

    assign want_mode = mode_req ? pvmt_pkg::MODE_TRUNK : pvmt_pkg::MODE_ACCESS;

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        ip_next      = ip_reg;
        valid_next   = valid_reg;
        chk_idx_next = chk_idx_reg;
        vid_next     = vid_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = vid_reg;
        ram_raddr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                // Slot 0 is fetched while idle so a trunk walk starts checking at once.
                ram_raddr = '0;
                if (start)
                begin
                    vid_next  = vlan_number;
                    done_next = 1'b1;
                    case (req_type)
                        pvmt_pkg::REQ_SET_MODE:
                        begin
                            if (ip_reg)
                            begin
                                ip_next     = 1'b0;
                                mode_next   = want_mode;
                                status_next = pvmt_pkg::ST_APPLIED;
                            end
                            else if (mode_reg == pvmt_pkg::MODE_UNKNOWN)
                            begin
                                mode_next   = want_mode;
                                status_next = pvmt_pkg::ST_APPLIED;
                            end
                            else if (mode_reg == want_mode)
                            begin
                                status_next = pvmt_pkg::ST_NOCHANGE;
                            end
                            else
                            begin
                                if (mode_reg == pvmt_pkg::MODE_TRUNK &&
                                    want_mode == pvmt_pkg::MODE_ACCESS)
                                begin
                                    valid_next = '0;
                                end
                                mode_next   = want_mode;
                                status_next = pvmt_pkg::ST_APPLIED;
                            end
                        end
                        pvmt_pkg::REQ_ADD_VLAN:
                        begin
                            if (ip_reg)
                            begin
                                status_next = pvmt_pkg::ST_L3;
                            end
                            else if (mode_reg == pvmt_pkg::MODE_ACCESS)
                            begin
                                // Slots above 0 are only ever written with non-zero VLANs.
                                status_next = (|valid_reg[SLOT_COUNT-1:1]) ?
                                              pvmt_pkg::ST_CLEARED : pvmt_pkg::ST_APPLIED;
                                valid_next  = SLOT_COUNT'(1);
                                ram_we      = 1'b1;
                                ram_waddr   = '0;
                                ram_wdata   = vlan_number;
                            end
                            else if (mode_reg != pvmt_pkg::MODE_TRUNK)
                            begin
                                status_next = pvmt_pkg::ST_NOL2;
                            end
                            else
                            begin
                                done_next    = 1'b0;
                                chk_idx_next = '0;
                                state_next   = S_SCAN;
                            end
                        end
                        pvmt_pkg::REQ_MARK_IP:
                        begin
                            ip_next     = 1'b1;
                            status_next = pvmt_pkg::ST_APPLIED;
                        end
                        default:
                        begin
                            status_next = pvmt_pkg::ST_NOCHANGE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                ram_raddr = chk_idx_reg + IDX_W'(1);
                if (cmp_res.hit)
                begin
                    status_next = pvmt_pkg::ST_NOCHANGE;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (cmp_res.empty)
                begin
                    ram_we                  = 1'b1;
                    ram_waddr               = chk_idx_reg;
                    ram_wdata               = vid_reg;
                    valid_next[chk_idx_reg] = 1'b1;
                    status_next             = pvmt_pkg::ST_APPLIED;
                    done_next               = 1'b1;
                    state_next              = S_IDLE;
                end
                else if (chk_idx_reg == LAST_IDX)
                begin
                    status_next = pvmt_pkg::ST_FULL;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    chk_idx_next = chk_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= pvmt_pkg::MODE_UNKNOWN;
            ip_reg      <= 1'b0;
            valid_reg   <= '0;
            chk_idx_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            ip_reg      <= ip_next;
            valid_reg   <= valid_next;
            chk_idx_reg <= chk_idx_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vid_reg    <= vid_next;
        status_reg <= status_next;
    end

    assign busy     = (state_reg == S_SCAN);
    assign done     = done_reg;
    assign status   = status_reg;
    assign mode_now = mode_reg;

    // A result word is only ever shown once the walk has finished.
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy)
        else $error("result word shown while the slot walk is running");

    // Every request other than a trunk-mode add gives its word in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !(req_type == pvmt_pkg::REQ_ADD_VLAN && !ip_reg &&
                             mode_reg == pvmt_pkg::MODE_TRUNK)) |=> done_reg)
        else $error("single-cycle request gave no result word");

    // A trunk add enters the walk and produces no word in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == pvmt_pkg::REQ_ADD_VLAN && !ip_reg &&
         mode_reg == pvmt_pkg::MODE_TRUNK) |=> (busy && !done_reg && chk_idx_reg == '0))
        else $error("trunk add did not start the slot walk");

    // The mode changes only on an accepted set-mode request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != $past(mode_reg)) |-> ($past(start) && !$past(busy) &&
                                           $past(req_type) == pvmt_pkg::REQ_SET_MODE))
        else $error("port mode changed without a set-mode request");

endmodule
